[rtl/core/hall_bldc_speed_controller_defines.svh]
// ----------------------------------------------------------------------------
// hall bldc speed controller assertion macros
// concurrent check helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef HALL_BLDC_SPEED_CONTROLLER_DEFINES_SVH
`define HALL_BLDC_SPEED_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/hbsc_pkg.sv]
// ----------------------------------------------------------------------------
// hbsc_pkg
// shared types, constants and tables of the hall bldc speed controller
// ----------------------------------------------------------------------------
package hbsc_pkg;

   localparam int CNT_W     = 5;
   localparam int RPM_W     = 13;
   localparam int NUM_SAMP  = 11;
   localparam int PI_PERIOD_DEFAULT    = 30;
   localparam int STALL_WINDOW_DEFAULT = 30;

   localparam logic [12:0] RPM_MIN     = 13'd700;
   localparam logic [12:0] RPM_MAX     = 13'd6000;
   localparam logic [15:0] RPM_SCALE   = 16'd60000;
   localparam int          INTEG_LIMIT = 20000;

   localparam logic [15:0] WORD_HI  = 16'hC301;
   localparam logic [15:0] WORD_PWM = 16'hC341;
   localparam logic [15:0] WORD_LO  = 16'hC101;

   // register indexes
   localparam logic [2:0] CSR_REVERSE = 3'd0;
   localparam logic [2:0] CSR_KP      = 3'd1;
   localparam logic [2:0] CSR_KI      = 3'd2;
   localparam logic [2:0] CSR_FLOOR   = 3'd3;
   localparam logic [2:0] CSR_CEIL    = 3'd4;
   localparam logic [2:0] CSR_CRUISE  = 3'd5;
   localparam logic [2:0] CSR_RUN     = 3'd6;
   localparam logic [2:0] CSR_RAMP    = 3'd7;

   localparam logic [4:0] SAMPLE_POS [NUM_SAMP] =
      '{5'd1, 5'd2, 5'd3, 5'd5, 5'd7, 5'd9, 5'd10, 5'd15, 5'd20, 5'd25, 5'd30};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LATCH,
      ST_EVENT,
      ST_MUL_P,
      ST_MUL_I,
      ST_PI,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic latch_upd;
      logic event_upd;
      logic mul_p;
      logic mul_i;
      logic pi_upd;
      logic div_start;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic pi_due;
      logic div_busy;
      logic out_busy;
   } status_type;

   // commutation tables
   function automatic logic [15:0] phase1_tab(input logic [2:0] idx);
      logic [15:0] w;
      unique case (idx)
         3'd1, 3'd3: w = WORD_PWM;
         3'd4, 3'd6: w = WORD_LO;
         default:    w = WORD_HI;
      endcase
      return w;
   endfunction

   function automatic logic [15:0] phase2_tab(input logic [2:0] idx);
      logic [15:0] w;
      unique case (idx)
         3'd2, 3'd3: w = WORD_LO;
         3'd4, 3'd5: w = WORD_PWM;
         default:    w = WORD_HI;
      endcase
      return w;
   endfunction

   function automatic logic [15:0] phase3_tab(input logic [2:0] idx);
      logic [15:0] w;
      unique case (idx)
         3'd1, 3'd5: w = WORD_LO;
         3'd2, 3'd6: w = WORD_PWM;
         default:    w = WORD_HI;
      endcase
      return w;
   endfunction

endpackage

[rtl/core/hbsc_req_if.sv]
// ----------------------------------------------------------------------------
// hbsc_req_if
// input item channel: one tick or hall edge with hall and button levels
// ----------------------------------------------------------------------------
interface hbsc_req_if;
   logic valid;
   logic ready;
   logic op;
   logic hall_a;
   logic hall_b;
   logic hall_c;
   logic start_button;
   logic stop_button;

   modport source (output valid, op, hall_a, hall_b, hall_c, start_button, stop_button,
                   input ready);
   modport sink   (input valid, op, hall_a, hall_b, hall_c, start_button, stop_button,
                   output ready);
endinterface

[rtl/core/hbsc_rsp_if.sv]
// ----------------------------------------------------------------------------
// hbsc_rsp_if
// result item channel: drive state, duty, phase words and speeds
// ----------------------------------------------------------------------------
interface hbsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_enable;
   logic [12:0] duty;
   logic [15:0] phase1_word;
   logic [15:0] phase2_word;
   logic [15:0] phase3_word;
   logic [12:0] measured_rpm;
   logic [12:0] target_rpm;
   logic        motor_running;

   modport source (output valid, drive_enable, duty, phase1_word, phase2_word,
                   phase3_word, measured_rpm, target_rpm, motor_running,
                   input ready);
   modport sink   (input valid, drive_enable, duty, phase1_word, phase2_word,
                   phase3_word, measured_rpm, target_rpm, motor_running,
                   output ready);
endinterface

[rtl/core/hbsc_divider.sv]
// ----------------------------------------------------------------------------
// hbsc_divider
// restoring divider, 60000 / divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hbsc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   import hbsc_pkg::*;

   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvd_ff, dvd_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] rem_sh;

   // one shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff[15:0], dvd_ff[15]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         rem_in  = 17'd0;
         dvd_in  = RPM_SCALE;
         quo_in  = 16'd0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[14:0], 1'b0};
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

[rtl/core/hbsc_datapath.sv]
// ----------------------------------------------------------------------------
// hbsc_datapath
// motor state, speed profile, stall detector, pi step and result register
// ----------------------------------------------------------------------------
module hbsc_datapath #(
   parameter int PI_PERIOD_TICKS = hbsc_pkg::PI_PERIOD_DEFAULT,
   parameter int STALL_WINDOW    = hbsc_pkg::STALL_WINDOW_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  hbsc_pkg::cmd_type   cmd,
   output hbsc_pkg::status_type status,
   input  logic                in_op,
   input  logic                in_hall_a,
   input  logic                in_hall_b,
   input  logic                in_hall_c,
   input  logic                in_start,
   input  logic                in_stop,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic                out_ready,
   output logic                out_valid,
   output logic                out_drive_enable,
   output logic [12:0]         out_duty,
   output logic [15:0]         out_phase1_word,
   output logic [15:0]         out_phase2_word,
   output logic [15:0]         out_phase3_word,
   output logic [12:0]         out_measured_rpm,
   output logic [12:0]         out_target_rpm,
   output logic                out_motor_running
);
   import hbsc_pkg::*;

   localparam logic [CNT_W-1:0] PI_PER = CNT_W'(PI_PERIOD_TICKS);
   localparam logic [CNT_W-1:0] WIN    = CNT_W'(STALL_WINDOW);

   // configuration
   logic        rev_dir_ff;
   logic [15:0] kp_ff, ki_ff;
   logic [12:0] floor_ff, ceil_ff, cruise_ff;
   logic [11:0] run_rev_ff;
   logic [10:0] ramp_rev_ff;

   // captured item
   logic       op_ff, start_ff, stop_ff;
   logic [2:0] code_ff;

   // motor state
   logic              latch_ff, latch_in;
   logic [11:0]       rev_cnt_ff, rev_cnt_in;
   logic [1:0]        first_rev_ff, first_rev_in;
   logic [15:0]       period_ff, period_in;
   logic [15:0]       lperiod_ff, lperiod_in;
   logic [15:0]       profile_ff, profile_in;
   logic [CNT_W-1:0]  window_ff, window_in;
   logic [2:0]        samples_ff [NUM_SAMP];
   logic [2:0]        samples_in [NUM_SAMP];
   logic              running_ff, running_in;
   logic [CNT_W-1:0]  pi_cnt_ff, pi_cnt_in;
   logic signed [15:0] integ_ff, integ_in;
   logic [12:0]       pi_duty_ff, pi_duty_in;
   logic [2:0]        hall_code_ff, hall_code_in;
   logic [12:0]       meas_ff, meas_in;
   logic signed [13:0] err_ff, err_in;
   logic signed [32:0] prod_p_ff, prod_i_ff;

   // result register
   logic        ov_ff, ov_in;
   logic        o_drive_ff;
   logic [12:0] o_duty_ff, o_meas_ff, o_tgt_ff;
   logic [15:0] o_w1_ff, o_w2_ff, o_w3_ff;
   logic        o_run_ff;

   // combinational helpers
   logic [12:0]        target;
   logic [CNT_W-1:0]   pi_cnt_inc;
   logic [CNT_W-1:0]   win_inc;
   logic signed [13:0] c_s, ramp_s, run_s;
   logic signed [16:0] integ_sum;
   logic signed [16:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [32:0] mul_out;
   logic signed [33:0] pi_sum;
   logic [33:0]        pi_mag;
   logic signed [19:0] delta;
   logic signed [19:0] new_duty;
   logic [15:0]        div_q;
   logic               div_busy;
   logic [12:0]        meas_new;
   logic [12:0]        duty_sel;
   logic [2:0]         tab_idx;

   hbsc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (lperiod_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rev_dir_ff  <= 1'b0;
         kp_ff       <= 16'd4588;
         ki_ff       <= 16'd197;
         floor_ff    <= 13'd400;
         ceil_ff     <= 13'd5600;
         cruise_ff   <= 13'd1000;
         run_rev_ff  <= 12'd200;
         ramp_rev_ff <= 11'd8;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REVERSE: rev_dir_ff  <= csr_wdata[0];
            CSR_KP:      kp_ff       <= csr_wdata;
            CSR_KI:      ki_ff       <= csr_wdata;
            CSR_FLOOR:   floor_ff    <= csr_wdata[12:0];
            CSR_CEIL:    ceil_ff     <= csr_wdata[12:0];
            CSR_CRUISE:  cruise_ff   <= csr_wdata[12:0];
            CSR_RUN:     run_rev_ff  <= csr_wdata[11:0];
            CSR_RAMP:    ramp_rev_ff <= csr_wdata[10:0];
         endcase
      end
   end

   // clamped target speed
   always_comb begin
      if (profile_ff < {3'd0, RPM_MIN}) begin
         target = RPM_MIN;
      end else if (profile_ff > {3'd0, RPM_MAX}) begin
         target = RPM_MAX;
      end else begin
         target = profile_ff[12:0];
      end
   end

   assign pi_cnt_inc = pi_cnt_ff + CNT_W'(1);
   assign win_inc    = window_ff + CNT_W'(1);
   assign c_s        = $signed({2'b00, rev_cnt_ff});
   assign ramp_s     = $signed({3'b000, ramp_rev_ff});
   assign run_s      = $signed({2'b00, run_rev_ff});
   assign integ_sum  = 17'(integ_ff) + 17'(err_ff);

   // shared multiplier
   always_comb begin
      if (cmd.mul_i) begin
         mul_a = $signed({1'b0, ki_ff});
         mul_b = integ_ff;
      end else begin
         mul_a = $signed({1'b0, kp_ff});
         mul_b = 16'(err_ff);
      end
   end
   assign mul_out = mul_a * mul_b;

   // pi correction, truncated toward zero
   always_comb begin
      pi_sum = 34'(prod_p_ff) + 34'(prod_i_ff);
      pi_mag = pi_sum[33] ? 34'(-pi_sum) : 34'(pi_sum);
      delta  = pi_sum[33] ? -$signed({2'b00, pi_mag[33:16]}) : $signed({2'b00, pi_mag[33:16]});
      new_duty = $signed({7'd0, pi_duty_ff}) + delta;
      if (new_duty < 0) begin
         new_duty = '0;
      end
      if (new_duty > $signed({7'd0, ceil_ff})) begin
         new_duty = $signed({7'd0, ceil_ff});
      end
   end

   // speed from the finished divide
   always_comb begin
      if (!running_ff || lperiod_ff == 16'd0) begin
         meas_new = 13'd0;
      end else if (div_q > {3'd0, RPM_MAX}) begin
         meas_new = RPM_MAX;
      end else begin
         meas_new = div_q[12:0];
      end
   end

   // state update per command
   always_comb begin
      latch_in     = latch_ff;
      rev_cnt_in   = rev_cnt_ff;
      first_rev_in = first_rev_ff;
      period_in    = period_ff;
      lperiod_in   = lperiod_ff;
      profile_in   = profile_ff;
      window_in    = window_ff;
      samples_in   = samples_ff;
      running_in   = running_ff;
      pi_cnt_in    = pi_cnt_ff;
      integ_in     = integ_ff;
      pi_duty_in   = pi_duty_ff;
      hall_code_in = hall_code_ff;
      meas_in      = meas_ff;
      err_in       = err_ff;

      // start latch and revolution counter
      if (cmd.latch_upd) begin
         latch_in = (latch_ff | start_ff) & (rev_cnt_ff != run_rev_ff) & ~stop_ff;
         if (rev_cnt_ff >= run_rev_ff || !latch_in) begin
            rev_cnt_in = 12'd0;
         end
         if (!latch_in) begin
            integ_in = 16'sd0;
         end
         err_in = $signed({1'b0, target}) - $signed({1'b0, meas_ff});
      end

      // tick or hall edge
      if (cmd.event_upd) begin
         if (!op_ff) begin
            if (latch_ff) begin
               if (period_ff != 16'hFFFF) begin
                  period_in = period_ff + 16'd1;
               end
               if (c_s <= ramp_s) begin
                  if (profile_ff != 16'hFFFF) begin
                     profile_in = profile_ff + 16'd1;
                  end
               end else if (c_s <= run_s - ramp_s) begin
                  profile_in = {3'd0, cruise_ff};
               end else if (c_s <= run_s) begin
                  if (profile_ff != 16'd0) begin
                     profile_in = profile_ff - 16'd1;
                  end
               end
            end else begin
               period_in    = 16'd0;
               lperiod_in   = 16'd0;
               first_rev_in = 2'd0;
               profile_in   = 16'd0;
            end
            window_in = (win_inc > WIN) ? CNT_W'(0) : win_inc;
            for (int i = 0; i < NUM_SAMP; i++) begin
               if (window_in == SAMPLE_POS[i]) begin
                  samples_in[i] = code_ff;
               end
            end
            running_in = 1'b0;
            for (int i = 1; i < NUM_SAMP; i++) begin
               if (samples_in[i] != samples_in[0]) begin
                  running_in = 1'b1;
               end
            end
            pi_cnt_in = (pi_cnt_inc == PI_PER) ? CNT_W'(0) : pi_cnt_inc;
         end else begin
            hall_code_in = code_ff;
            if (code_ff == 3'd1 && latch_ff) begin
               if (first_rev_ff != 2'd3) begin
                  first_rev_in = first_rev_ff + 2'd1;
               end
               rev_cnt_in = rev_cnt_ff + 12'd1;
               if (first_rev_in > 2'd1) begin
                  lperiod_in   = period_ff;
                  period_in    = 16'd0;
                  first_rev_in = 2'd2;
               end else begin
                  lperiod_in = 16'd0;
               end
            end
         end
      end

      // integral accumulate, reset to zero past the limit or when the drive is off
      if (cmd.mul_p) begin
         if (!latch_ff) begin
            integ_in = 16'sd0;
         end else if (integ_sum > 17'sd20000 || integ_sum < -17'sd20000) begin
            integ_in = 16'sd0;
         end else begin
            integ_in = integ_sum[15:0];
         end
      end

      if (cmd.pi_upd) begin
         pi_duty_in = latch_ff ? new_duty[12:0] : 13'd0;
      end

      if (cmd.load_out) begin
         meas_in = meas_new;
      end
   end

   // result values
   assign tab_idx = rev_dir_ff ? (3'd7 - hall_code_ff) : hall_code_ff;
   always_comb begin
      duty_sel = pi_duty_ff;
      if (duty_sel < floor_ff) begin
         duty_sel = floor_ff;
      end
      if (duty_sel > ceil_ff) begin
         duty_sel = ceil_ff;
      end
   end

   // output valid flag
   always_comb begin
      ov_in = ov_ff;
      if (ov_ff && out_ready) begin
         ov_in = 1'b0;
      end
      if (cmd.load_out) begin
         ov_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff     <= 1'b0;
         rev_cnt_ff   <= 12'd0;
         first_rev_ff <= 2'd0;
         period_ff    <= 16'd0;
         lperiod_ff   <= 16'd0;
         profile_ff   <= 16'd0;
         window_ff    <= '0;
         for (int i = 0; i < NUM_SAMP; i++) begin
            samples_ff[i] <= 3'd0;
         end
         running_ff   <= 1'b0;
         pi_cnt_ff    <= '0;
         integ_ff     <= 16'sd0;
         pi_duty_ff   <= 13'd0;
         hall_code_ff <= 3'd0;
         meas_ff      <= 13'd0;
         ov_ff        <= 1'b0;
      end else begin
         latch_ff     <= latch_in;
         rev_cnt_ff   <= rev_cnt_in;
         first_rev_ff <= first_rev_in;
         period_ff    <= period_in;
         lperiod_ff   <= lperiod_in;
         profile_ff   <= profile_in;
         window_ff    <= window_in;
         samples_ff   <= samples_in;
         running_ff   <= running_in;
         pi_cnt_ff    <= pi_cnt_in;
         integ_ff     <= integ_in;
         pi_duty_ff   <= pi_duty_in;
         hall_code_ff <= hall_code_in;
         meas_ff      <= meas_in;
         ov_ff        <= ov_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      err_ff <= err_in;
      if (cmd.capture) begin
         op_ff    <= in_op;
         start_ff <= in_start;
         stop_ff  <= in_stop;
         code_ff  <= {in_hall_a, in_hall_c, in_hall_b};
      end
      if (cmd.mul_p) begin
         prod_p_ff <= mul_out;
      end
      if (cmd.mul_i) begin
         prod_i_ff <= mul_out;
      end
      if (cmd.load_out) begin
         o_drive_ff <= latch_ff;
         o_duty_ff  <= latch_ff ? duty_sel : 13'd0;
         o_w1_ff    <= latch_ff ? phase1_tab(tab_idx) : 16'd0;
         o_w2_ff    <= latch_ff ? phase2_tab(tab_idx) : 16'd0;
         o_w3_ff    <= latch_ff ? phase3_tab(tab_idx) : 16'd0;
         o_meas_ff  <= meas_new;
         o_tgt_ff   <= target;
         o_run_ff   <= running_ff;
      end
   end

   assign status.pi_due   = ~op_ff & (pi_cnt_inc == PI_PER);
   assign status.div_busy = div_busy;
   assign status.out_busy = ov_ff & ~out_ready;

   assign out_valid         = ov_ff;
   assign out_drive_enable  = o_drive_ff;
   assign out_duty          = o_duty_ff;
   assign out_phase1_word   = o_w1_ff;
   assign out_phase2_word   = o_w2_ff;
   assign out_phase3_word   = o_w3_ff;
   assign out_measured_rpm  = o_meas_ff;
   assign out_target_rpm    = o_tgt_ff;
   assign out_motor_running = o_run_ff;
endmodule

[rtl/core/hbsc_ctrl.sv]
// ----------------------------------------------------------------------------
// hbsc_ctrl
// sequencer: latch, event, optional pi step, speed divide, result load
// ----------------------------------------------------------------------------
module hbsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hbsc_pkg::status_type status,
   output hbsc_pkg::cmd_type    cmd
);
   import hbsc_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (in_valid) state_in = ST_LATCH;
         ST_LATCH:     state_in = ST_EVENT;
         ST_EVENT:     state_in = status.pi_due ? ST_MUL_P : ST_DIV_START;
         ST_MUL_P:     state_in = ST_MUL_I;
         ST_MUL_I:     state_in = ST_PI;
         ST_PI:        state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_RUN;
         ST_DIV_RUN:   if (!status.div_busy) state_in = ST_DONE;
         ST_DONE:      if (!status.out_busy) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready    = 1'b1;
            cmd.capture = in_valid;
         end
         ST_LATCH:     cmd.latch_upd = 1'b1;
         ST_EVENT:     cmd.event_upd = 1'b1;
         ST_MUL_P:     cmd.mul_p     = 1'b1;
         ST_MUL_I:     cmd.mul_i     = 1'b1;
         ST_PI:        cmd.pi_upd    = 1'b1;
         ST_DIV_START: cmd.div_start = 1'b1;
         ST_DIV_RUN:   cmd           = '0;
         ST_DONE:      cmd.load_out  = ~status.out_busy;
         default:      cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[rtl/core/hall_bldc_speed_controller.sv]
// ----------------------------------------------------------------------------
// hall_bldc_speed_controller
// sensored bldc six-step commutation with pi speed control
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  req_if   | in        | op, hall levels, start and stop buttons
//  rsp_if   | out       | drive enable, duty, phase words, speeds, running
//  csr_*    | in        | register write: enable, index, data
//
// an item passes the latch and event steps, an optional pi step, the speed divide
// and the result load; the 16-step speed divider is the longest of these
// one item is in work at a time; the next is taken while a result waits
// reset is synchronous and restores register defaults and zero state
// a stalled result holds the sequencer in its final step only
`include "hall_bldc_speed_controller_defines.svh"
module hall_bldc_speed_controller #(
   parameter int PI_PERIOD_TICKS = hbsc_pkg::PI_PERIOD_DEFAULT,
   parameter int STALL_WINDOW    = hbsc_pkg::STALL_WINDOW_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   hbsc_req_if.sink    req_if,
   hbsc_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import hbsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   hbsc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .status   (status),
      .cmd      (cmd)
   );

   hbsc_datapath #(
      .PI_PERIOD_TICKS (PI_PERIOD_TICKS),
      .STALL_WINDOW    (STALL_WINDOW)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .in_op             (req_if.op),
      .in_hall_a         (req_if.hall_a),
      .in_hall_b         (req_if.hall_b),
      .in_hall_c         (req_if.hall_c),
      .in_start          (req_if.start_button),
      .in_stop           (req_if.stop_button),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .out_ready         (rsp_if.ready),
      .out_valid         (rsp_if.valid),
      .out_drive_enable  (rsp_if.drive_enable),
      .out_duty          (rsp_if.duty),
      .out_phase1_word   (rsp_if.phase1_word),
      .out_phase2_word   (rsp_if.phase2_word),
      .out_phase3_word   (rsp_if.phase3_word),
      .out_measured_rpm  (rsp_if.measured_rpm),
      .out_target_rpm    (rsp_if.target_rpm),
      .out_motor_running (rsp_if.motor_running)
   );

   // checks
   `ASSERT_IMPLY(a_drive_off_quiet, clock, reset, rsp_if.valid && !rsp_if.drive_enable, rsp_if.duty == 13'd0 && rsp_if.phase1_word == 16'd0 && rsp_if.phase2_word == 16'd0 && rsp_if.phase3_word == 16'd0)
   `ASSERT_IMPLY(a_target_range, clock, reset, rsp_if.valid, rsp_if.target_rpm >= RPM_MIN && rsp_if.target_rpm <= RPM_MAX)
   `ASSERT_IMPLY(a_meas_range, clock, reset, rsp_if.valid, rsp_if.measured_rpm <= RPM_MAX)
   `ASSERT_NEXT(a_one_in_work, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
endmodule

[tb/tb_hall_bldc_speed_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hall_bldc_speed_controller
// self-checking bench: a speed controller predictor runs beside the block and
// every result item is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------

// predicted result item
typedef struct packed {
   logic        drive_enable;
   logic [12:0] duty;
   logic [15:0] phase1_word;
   logic [15:0] phase2_word;
   logic [15:0] phase3_word;
   logic [12:0] measured_rpm;
   logic [12:0] target_rpm;
   logic        motor_running;
} motor_status_t;

class speed_ctrl_scoreboard;
   // register copies
   logic        reverse;
   logic [15:0] kp, ki;
   logic [12:0] floor_duty, ceil_duty, cruise;
   logic [11:0] run_revs;
   logic [10:0] ramp_revs;
   // controller state
   logic        latch;
   logic [11:0] revs;
   logic [1:0]  first_seen;
   logic [15:0] period_cnt, period_latched, profile;
   logic [4:0]  window, pi_cnt;
   logic [2:0]  samples [hbsc_pkg::NUM_SAMP];
   logic        running;
   int          integ;
   logic [12:0] pi_duty;
   logic [2:0]  hall;
   motor_status_t pending [$];
   int          mismatches;

   function void clear();
      reverse = 0; kp = 16'd4588; ki = 16'd197; floor_duty = 13'd400;
      ceil_duty = 13'd5600; cruise = 13'd1000; run_revs = 12'd200; ramp_revs = 11'd8;
      latch = 0; revs = 0; first_seen = 0; period_cnt = 0; period_latched = 0;
      profile = 0; window = 0; pi_cnt = 0; running = 0; integ = 0; pi_duty = 0;
      hall = 0;
      foreach (samples[i]) samples[i] = 0;
      pending.delete();
      mismatches = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
         hbsc_pkg::CSR_REVERSE: reverse    = val[0];
         hbsc_pkg::CSR_KP:      kp         = val;
         hbsc_pkg::CSR_KI:      ki         = val;
         hbsc_pkg::CSR_FLOOR:   floor_duty = val[12:0];
         hbsc_pkg::CSR_CEIL:    ceil_duty  = val[12:0];
         hbsc_pkg::CSR_CRUISE:  cruise     = val[12:0];
         hbsc_pkg::CSR_RUN:     run_revs   = val[11:0];
         hbsc_pkg::CSR_RAMP:    ramp_revs  = val[10:0];
         default: ;
      endcase
   endfunction

   function int target_speed();
      int t;
      t = profile;
      if (t < hbsc_pkg::RPM_MIN) t = hbsc_pkg::RPM_MIN;
      if (t > hbsc_pkg::RPM_MAX) t = hbsc_pkg::RPM_MAX;
      return t;
   endfunction

   function int measured_speed();
      int m;
      if (!running || period_latched == 0) return 0;
      m = 60000 / period_latched;
      return (m > hbsc_pkg::RPM_MAX) ? hbsc_pkg::RPM_MAX : m;
   endfunction

   // revolution based ramp, plateau, ramp
   function void advance_profile();
      int c, rp, rn;
      c = revs; rp = ramp_revs; rn = run_revs;
      if (c <= rp) begin
         if (profile != 16'hFFFF) profile++;
      end else if (c <= rn - rp) begin
         profile = {3'b0, cruise};
      end else if (c <= rn) begin
         if (profile != 0) profile--;
      end
   endfunction

   function void pi_update(int err);
      longint s, d, nd;
      if (!latch) begin
         pi_duty = 0; integ = 0;
         return;
      end
      integ += err;
      if (integ > hbsc_pkg::INTEG_LIMIT || integ < -hbsc_pkg::INTEG_LIMIT) integ = 0;
      s = longint'(kp) * err + longint'(ki) * integ;
      d = (s >= 0) ? (s >>> 16) : -((-s) >>> 16);
      nd = longint'(pi_duty) + d;
      if (nd < 0) nd = 0;
      if (nd > ceil_duty) nd = ceil_duty;
      pi_duty = nd[12:0];
   endfunction

   // accepted input item: advance the state and queue the result
   function void note_item(logic op, logic ha, logic hb, logic hc, logic st, logic sp);
      logic [2:0]  code, idx;
      logic [15:0] p1 [8];
      logic [15:0] p2 [8];
      logic [15:0] p3 [8];
      logic [4:0]  spos [hbsc_pkg::NUM_SAMP];
      int          err, w, dt;
      motor_status_t r;
      p1 = '{hbsc_pkg::WORD_HI, hbsc_pkg::WORD_PWM, hbsc_pkg::WORD_HI, hbsc_pkg::WORD_PWM,
             hbsc_pkg::WORD_LO, hbsc_pkg::WORD_HI, hbsc_pkg::WORD_LO, hbsc_pkg::WORD_HI};
      p2 = '{hbsc_pkg::WORD_HI, hbsc_pkg::WORD_HI, hbsc_pkg::WORD_LO, hbsc_pkg::WORD_LO,
             hbsc_pkg::WORD_PWM, hbsc_pkg::WORD_PWM, hbsc_pkg::WORD_HI, hbsc_pkg::WORD_HI};
      p3 = '{hbsc_pkg::WORD_HI, hbsc_pkg::WORD_LO, hbsc_pkg::WORD_PWM, hbsc_pkg::WORD_HI,
             hbsc_pkg::WORD_HI, hbsc_pkg::WORD_LO, hbsc_pkg::WORD_PWM, hbsc_pkg::WORD_HI};
      spos = '{5'd1, 5'd2, 5'd3, 5'd5, 5'd7, 5'd9, 5'd10, 5'd15, 5'd20, 5'd25, 5'd30};
      code = {ha, hc, hb};
      // buttons and revolution limit
      latch = (latch | st) & (revs != run_revs) & ~sp;
      if (revs >= run_revs || !latch) revs = 0;
      if (!latch) integ = 0;
      err = target_speed() - measured_speed();
      if (op == 1'b0) begin
         if (latch) begin
            if (period_cnt != 16'hFFFF) period_cnt++;
            advance_profile();
         end else begin
            period_cnt = 0; period_latched = 0; first_seen = 0; profile = 0;
         end
         // stall window
         w = window + 1;
         if (w > 30) w = 0;
         window = w[4:0];
         foreach (spos[i]) if (window == spos[i]) samples[i] = code;
         running = 0;
         for (int i = 1; i < hbsc_pkg::NUM_SAMP; i++)
            if (samples[i] != samples[0]) running = 1;
         pi_cnt = pi_cnt + 5'd1;
         if (pi_cnt == 5'd30) begin
            pi_update(err);
            pi_cnt = 0;
         end
      end else begin
         hall = code;
         if (code == 3'd1 && latch) begin
            if (first_seen < 3) first_seen++;
            revs = revs + 12'd1;
            if (first_seen > 1) begin
               period_latched = period_cnt;
               period_cnt = 0;
               first_seen = 2;
            end else begin
               period_latched = 0;
            end
         end
      end
      // result item
      r = '0;
      r.drive_enable = latch;
      if (latch) begin
         dt = pi_duty;
         if (dt < floor_duty) dt = floor_duty;
         if (dt > ceil_duty) dt = ceil_duty;
         r.duty = dt[12:0];
         idx = reverse ? (3'd7 - hall) : hall;
         r.phase1_word = p1[idx];
         r.phase2_word = p2[idx];
         r.phase3_word = p3[idx];
      end
      r.measured_rpm = measured_speed();
      r.target_rpm = target_speed();
      r.motor_running = running;
      pending.push_back(r);
   endfunction

   function void check_result(motor_status_t got);
      motor_status_t exp;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result item %h", got);
         return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp en=%0d duty=%0d w=%h/%h/%h meas=%0d tgt=%0d run=%0d | got en=%0d duty=%0d w=%h/%h/%h meas=%0d tgt=%0d run=%0d",
               exp.drive_enable, exp.duty, exp.phase1_word, exp.phase2_word, exp.phase3_word,
               exp.measured_rpm, exp.target_rpm, exp.motor_running,
               got.drive_enable, got.duty, got.phase1_word, got.phase2_word, got.phase3_word,
               got.measured_rpm, got.target_rpm, got.motor_running);
      end
   endfunction
endclass

module tb_hall_bldc_speed_controller;
   import hbsc_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int DRAIN_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   hbsc_req_if  req_if();
   hbsc_rsp_if  rsp_if();

   speed_ctrl_scoreboard speed_sb;
   int          cycles;
   int          items_sent;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;
   bit          hold_done;
   int          hall_pos;
   logic [2:0]  hall_seq [6];

   hall_bldc_speed_controller dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: check accepted items and drive ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            speed_sb.check_result({rsp_if.drive_enable, rsp_if.duty, rsp_if.phase1_word,
               rsp_if.phase2_word, rsp_if.phase3_word, rsp_if.measured_rpm,
               rsp_if.target_rpm, rsp_if.motor_running});
         // one long hold-off to back up the block
         if (!hold_done && items_sent >= 150) begin
            hold_done <= 1'b1;
            hold_cycles <= 400;
            rsp_if.ready <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      speed_sb.set_reg(idx, val);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (speed_sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(input logic op, input logic [2:0] code,
                            input logic st, input logic sp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.hall_a <= code[2];
      req_if.hall_c <= code[1];
      req_if.hall_b <= code[0];
      req_if.start_button <= st;
      req_if.stop_button <= sp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      speed_sb.note_item(op, code[2], code[0], code[1], st, sp);
      items_sent++;
      if (items_sent < 320) begin
         send_idle_pct = 32; recv_idle_pct = 65;
      end else if (items_sent < 640) begin
         send_idle_pct = 65; recv_idle_pct = 32;
      end else begin
         send_idle_pct = 0; recv_idle_pct = 0;
      end
      // one pause until the block has drained
      if (items_sent == 500) begin
         req_if.valid <= 1'b0;
         while (speed_sb.pending.size() != 0) @(posedge clock);
      end
   endtask

   task automatic write_all(input logic rev, input logic [15:0] p, input logic [15:0] i,
                            input logic [12:0] fl, input logic [12:0] cl,
                            input logic [12:0] cr, input logic [11:0] rn,
                            input logic [10:0] rp);
      write_reg(CSR_REVERSE, {15'd0, rev});
      write_reg(CSR_KP, p);
      write_reg(CSR_KI, i);
      write_reg(CSR_FLOOR, {3'd0, fl});
      write_reg(CSR_CEIL, {3'd0, cl});
      write_reg(CSR_CRUISE, {3'd0, cr});
      write_reg(CSR_RUN, {4'd0, rn});
      write_reg(CSR_RAMP, {5'd0, rp});
   endtask

   // spinning motor with random speed, button presses, stalls and noise
   task automatic spin_motor(input int count);
      int edge_pct, r;
      logic [2:0] code;
      edge_pct = 30;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) edge_pct = $urandom_range(80, 3);
         r = $urandom_range(99);
         if (r < 4) begin
            code = $urandom_range(7);
            send_item($urandom_range(1), code, $urandom_range(1), $urandom_range(1));
         end else if (r < 4 + edge_pct * 96 / 100) begin
            hall_pos = (hall_pos + 1) % 6;
            send_item(1'b1, hall_seq[hall_pos], $urandom_range(99) < 6,
                      $urandom_range(199) == 0);
         end else begin
            send_item(1'b0, hall_seq[hall_pos], $urandom_range(99) < 6,
                      $urandom_range(199) == 0);
         end
      end
   endtask

   initial begin
      speed_sb = new();
      speed_sb.clear();
      hall_seq = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
      hall_pos = 0;
      cycles = 0; items_sent = 0; hold_cycles = 0; hold_done = 0;
      send_idle_pct = 32; recv_idle_pct = 65;
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_if.valid = 1'b0; req_if.op = 1'b0; req_if.hall_a = 1'b0; req_if.hall_b = 1'b0;
      req_if.hall_c = 1'b0; req_if.start_button = 1'b0; req_if.stop_button = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: drive off and on by the buttons, all hall codes and reverse
      send_item(1'b0, 3'd7, 1'b0, 1'b0);
      send_item(1'b1, 3'd0, 1'b0, 1'b1);
      send_item(1'b1, 3'd1, 1'b1, 1'b1);
      send_item(1'b0, 3'd1, 1'b1, 1'b0);
      for (int c = 0; c < 8; c++) send_item(1'b1, c[2:0], 1'b0, 1'b0);
      for (int t = 0; t < 8; t++) send_item(1'b0, t[2:0], 1'b0, 1'b0);
      send_item(1'b1, 3'd1, 1'b0, 1'b0);
      send_item(1'b0, 3'd7, 1'b0, 1'b1);
      send_item(1'b1, 3'd7, 1'b0, 1'b0);
      wait_idle();
      write_reg(CSR_REVERSE, 16'd1);
      send_item(1'b1, 3'd0, 1'b1, 1'b0);
      send_item(1'b1, 3'd6, 1'b0, 1'b0);
      send_item(1'b0, 3'd6, 1'b0, 1'b0);
      wait_idle();

      // phase with register defaults, reverse still set
      spin_motor(230);
      wait_idle();
      // extremes: full gains, wide limits, top cruise, one revolution
      write_all(1'b1, 16'hFFFF, 16'hFFFF, 13'd0, 13'd8191, 13'd6000, 12'd1, 11'd2047);
      spin_motor(80);
      wait_idle();
      write_reg(CSR_RUN, 16'd4095);
      write_reg(CSR_RAMP, 16'd0);
      spin_motor(150);
      wait_idle();
      // crossed limits, zero gains and cruise
      write_all(1'b0, 16'd0, 16'd0, 13'd8191, 13'd0, 13'd0, 12'd4095, 11'd0);
      spin_motor(200);
      wait_idle();
      // short runs with a plateau
      write_all(1'b0, 16'd20000, 16'd3000, 13'd300, 13'd4000, 13'd3000, 12'd12, 11'd3);
      spin_motor(280);

      wait_idle();
      if (speed_sb.mismatches == 0 && speed_sb.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/hbsc_pkg.sv
rtl/core/hbsc_req_if.sv
rtl/core/hbsc_rsp_if.sv
rtl/core/hbsc_divider.sv
rtl/core/hbsc_datapath.sv
rtl/core/hbsc_ctrl.sv
rtl/core/hall_bldc_speed_controller.sv
tb/tb_hall_bldc_speed_controller.sv
